[src/rtemp_pkg.sv]
// package for the radiometric raw-to-temperature unit
// holds register indexes, reset values, fixed constants and the per-transaction flag type
// no dependencies
package rtemp_pkg;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_R1      = 3'd0;
    localparam t_cfg_idx CFG_R2      = 3'd1;
    localparam t_cfg_idx CFG_B       = 3'd2;
    localparam t_cfg_idx CFG_OFFSET  = 3'd3;
    localparam t_cfg_idx CFG_F       = 3'd4;
    localparam t_cfg_idx CFG_SCALE   = 3'd5;
    localparam t_cfg_idx CFG_CELSIUS = 3'd6;

    localparam int CFG_W = 32;

    localparam logic [31:0] RST_R1      = 32'd970551198;
    localparam logic [31:0] RST_R2      = 32'd45680619;
    localparam logic [31:0] RST_B       = 32'd90413466;
    localparam logic [16:0] RST_OFFSET  = 17'h1E92A;
    localparam logic [23:0] RST_F       = 24'd65536;
    localparam logic [23:0] RST_SCALE   = 24'd25600;
    localparam logic        RST_CELSIUS = 1'b1;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [40:0] KZERO_Q16 = 41'd17901158;
    localparam logic [15:0] VAL_MAX   = 16'hFFFF;

    typedef struct packed {
        logic err;
        logic zero;
        logic sat;
        logic inf;
        logic big;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage

[src/rtemp_div.sv]
// pipelined restoring divider, one quotient bit per stage
// carries a sideband vector alongside each transaction; no package dependency
module rtemp_div #(
    parameter int DW = 49,
    parameter int QW = 56,
    parameter int SW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [QW-1:0] i_num,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_valid [QW];
    logic [DW-1:0] r_rem   [QW];
    logic [DW-1:0] r_den   [QW];
    logic [QW-1:0] r_num   [QW];
    logic [QW-1:0] r_quo   [QW];
    logic [SW-1:0] r_side  [QW];

    generate
        for (genvar k = 0; k < QW; k++) begin : g_stage
            logic          p_valid;
            logic [DW-1:0] p_rem;
            logic [DW-1:0] p_den;
            logic [QW-1:0] p_num;
            logic [QW-1:0] p_quo;
            logic [SW-1:0] p_side;
            logic [DW:0]   rs;
            logic [DW:0]   diff;
            logic          ge;
            logic [DW-1:0] n_rem;

            if (k == 0) begin : g_first
                assign p_valid = i_valid;
                assign p_rem   = i_rem;
                assign p_den   = i_den;
                assign p_num   = i_num;
                assign p_quo   = '0;
                assign p_side  = i_side;
            end else begin : g_next
                assign p_valid = r_valid[k-1];
                assign p_rem   = r_rem[k-1];
                assign p_den   = r_den[k-1];
                assign p_num   = r_num[k-1];
                assign p_quo   = r_quo[k-1];
                assign p_side  = r_side[k-1];
            end

            assign rs    = {p_rem, p_num[QW-1]};
            assign diff  = rs - {1'b0, p_den};
            assign ge    = (rs >= {1'b0, p_den});
            assign n_rem = ge ? diff[DW-1:0] : rs[DW-1:0];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= p_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_den[k]  <= p_den;
                    r_num[k]  <= {p_num[QW-2:0], 1'b0};
                    r_quo[k]  <= {p_quo[QW-2:0], ge};
                    r_side[k] <= p_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

[src/radiometric_raw_to_temperature_unit.sv]
// top level of the radiometric raw-to-temperature unit (planck form, fixed point)
// depends on rtemp_pkg and rtemp_div
//
//  channel   signals                                   direction
//  input     i_valid, o_stall, i_raw_word              in
//  output    o_valid, i_stall, o_scaled_temperature,   out
//            o_domain_error
//  config    i_cfg_wr_en, i_cfg_index, i_cfg_wr_data   in
//
// one transaction per cycle while the output is not stalled; the depth comes mostly from the two
// bit-per-stage dividers (56 and 41 stages), the 6-step normalise and the 24 log squarings
// a stall at the output freezes the whole pipeline; o_stall follows it
// reset is synchronous, clears valid bits and loads the configuration registers with their reset values
module radiometric_raw_to_temperature_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [15:0]              i_raw_word,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [15:0]              o_scaled_temperature,
    output logic                     o_domain_error,
    input  logic                     i_cfg_wr_en,
    input  rtemp_pkg::t_cfg_idx      i_cfg_index,
    input  logic [rtemp_pkg::CFG_W-1:0] i_cfg_wr_data
);
    import rtemp_pkg::*;

    localparam int NORM_N = 6;
    localparam int SQ_N   = 24;
    localparam int XW     = 57;

    logic [31:0] r_r1;
    logic [31:0] r_r2;
    logic [31:0] r_b;
    logic [16:0] r_off;
    logic [23:0] r_f;
    logic [23:0] r_scale;
    logic        r_cels;

    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1    <= RST_R1;
            r_r2    <= RST_R2;
            r_b     <= RST_B;
            r_off   <= RST_OFFSET;
            r_f     <= RST_F;
            r_scale <= RST_SCALE;
            r_cels  <= RST_CELSIUS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_R1:      r_r1    <= i_cfg_wr_data;
                CFG_R2:      r_r2    <= i_cfg_wr_data;
                CFG_B:       r_b     <= i_cfg_wr_data;
                CFG_OFFSET:  r_off   <= i_cfg_wr_data[16:0];
                CFG_F:       r_f     <= i_cfg_wr_data[23:0];
                CFG_SCALE:   r_scale <= i_cfg_wr_data[23:0];
                CFG_CELSIUS: r_cels  <= i_cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    logic        r_out_valid;
    logic [15:0] r_out_val;
    logic        r_out_err;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // count plus offset
    logic [15:0] s_cnt;
    logic [17:0] n_d;
    logic        r1_valid;
    logic [17:0] r1_d;
    logic        r1_err;

    assign s_cnt = {i_raw_word[7:0], i_raw_word[15:8]};
    assign n_d   = {2'b00, s_cnt} + {r_off[16], r_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d   <= n_d;
            r1_err <= n_d[17] || (n_d == '0);
        end
    end

    // denominator r2 * d
    logic        r2_valid;
    logic [48:0] r2_dd;
    logic        r2_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_dd  <= 49'(r_r2) * 49'(r1_d[16:0]);
            r2_err <= r1_err;
        end
    end

    // ratio divider
    t_flags      d1_in_flags;
    logic        d1_valid;
    logic [55:0] d1_quo;
    logic [FLAGS_W-1:0] d1_side;
    t_flags      d1_flags;

    always_comb begin
        d1_in_flags      = '0;
        d1_in_flags.err  = r2_err;
        d1_in_flags.sat  = (r2_dd[48:16] == '0) && ({r2_dd[15:0], 16'h0000} <= r_r1);
    end

    rtemp_div #(.DW(49), .QW(56), .SW(FLAGS_W)) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_valid),
        .i_rem   (49'(r_r1[31:16])),
        .i_den   (r2_dd),
        .i_num   ({r_r1[15:0], 40'h0}),
        .i_side  (d1_in_flags),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    assign d1_flags = t_flags'(d1_side);

    // log argument
    logic [55:0]   ratio;
    logic [XW-1:0] n_x;
    t_flags        n_r3_flags;
    logic          r3_valid;
    logic [XW-1:0] r3_x;
    t_flags        r3_flags;

    assign ratio = d1_flags.sat ? {56{1'b1}} : d1_quo;
    assign n_x   = XW'(ratio) + XW'({r_f, 8'h00});

    always_comb begin
        n_r3_flags      = d1_flags;
        n_r3_flags.zero = d1_flags.zero || (n_x == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_x     <= n_x;
            r3_flags <= n_r3_flags;
        end
    end

    // normalise, one shift step per stage
    logic          r_nm_valid [NORM_N];
    logic [XW-1:0] r_nm_x     [NORM_N];
    logic [5:0]    r_nm_lz    [NORM_N];
    t_flags        r_nm_flags [NORM_N];

    generate
        for (genvar k = 0; k < NORM_N; k++) begin : g_norm
            localparam int SH = 1 << (NORM_N - 1 - k);
            logic          p_valid;
            logic [XW-1:0] p_x;
            logic [5:0]    p_lz;
            t_flags        p_flags;
            logic          hit;

            if (k == 0) begin : g_first
                assign p_valid = r3_valid;
                assign p_x     = r3_x;
                assign p_lz    = '0;
                assign p_flags = r3_flags;
            end else begin : g_next
                assign p_valid = r_nm_valid[k-1];
                assign p_x     = r_nm_x[k-1];
                assign p_lz    = r_nm_lz[k-1];
                assign p_flags = r_nm_flags[k-1];
            end

            assign hit = (p_x[XW-1 -: SH] == '0);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_nm_valid[k] <= 1'b0;
                end else if (en) begin
                    r_nm_valid[k] <= p_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_nm_x[k]     <= hit ? (p_x << SH) : p_x;
                    r_nm_lz[k]    <= hit ? (p_lz | 6'(SH)) : p_lz;
                    r_nm_flags[k] <= p_flags;
                end
            end
        end
    endgenerate

    // log2 fraction by repeated squaring
    logic   [30:0] nm_m;
    logic   [5:0]  nm_ip;
    t_flags        nm_flags;

    assign nm_m  = r_nm_x[NORM_N-1][XW-1 -: 31];
    assign nm_ip = 6'(7'd32 - {1'b0, r_nm_lz[NORM_N-1]});

    always_comb begin
        nm_flags      = r_nm_flags[NORM_N-1];
        nm_flags.zero = r_nm_flags[NORM_N-1].zero || (r_nm_lz[NORM_N-1] > 6'd32);
    end

    logic          r_sq_valid [SQ_N];
    logic [30:0]   r_sq_m     [SQ_N];
    logic [23:0]   r_sq_f     [SQ_N];
    logic [5:0]    r_sq_ip    [SQ_N];
    t_flags        r_sq_flags [SQ_N];

    generate
        for (genvar k = 0; k < SQ_N; k++) begin : g_sq
            logic        p_valid;
            logic [30:0] p_m;
            logic [23:0] p_f;
            logic [5:0]  p_ip;
            t_flags      p_flags;
            logic [61:0] prod;
            logic [31:0] sq;

            if (k == 0) begin : g_first
                assign p_valid = r_nm_valid[NORM_N-1];
                assign p_m     = nm_m;
                assign p_f     = '0;
                assign p_ip    = nm_ip;
                assign p_flags = nm_flags;
            end else begin : g_next
                assign p_valid = r_sq_valid[k-1];
                assign p_m     = r_sq_m[k-1];
                assign p_f     = r_sq_f[k-1];
                assign p_ip    = r_sq_ip[k-1];
                assign p_flags = r_sq_flags[k-1];
            end

            assign prod = 62'(p_m) * 62'(p_m);
            assign sq   = prod[61:30];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_valid[k] <= 1'b0;
                end else if (en) begin
                    r_sq_valid[k] <= p_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_m[k]     <= sq[31] ? sq[31:1] : sq[30:0];
                    r_sq_f[k]     <= {p_f[22:0], sq[31]};
                    r_sq_ip[k]    <= p_ip;
                    r_sq_flags[k] <= p_flags;
                end
            end
        end
    endgenerate

    // natural log
    logic [29:0] lg;
    logic [61:0] ln_prod;
    logic        r5_valid;
    logic [29:0] r5_lnq;
    t_flags      r5_flags;

    assign lg      = {r_sq_ip[SQ_N-1], r_sq_f[SQ_N-1]};
    assign ln_prod = 62'(lg) * 62'(LN2_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= r_sq_valid[SQ_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_lnq   <= ln_prod[61:32];
            r5_flags <= r_sq_flags[SQ_N-1];
        end
    end

    // temperature divider
    t_flags      d2_in_flags;
    logic        d2_valid;
    logic [40:0] d2_quo;
    logic [FLAGS_W-1:0] d2_side;
    t_flags      d2_flags;

    always_comb begin
        d2_in_flags     = r5_flags;
        d2_in_flags.inf = (r5_lnq == '0);
        d2_in_flags.big = (r5_lnq != '0) && (r5_lnq[29:15] == '0)
                          && ({r5_lnq[14:0], 17'h0} <= r_b);
    end

    rtemp_div #(.DW(30), .QW(41), .SW(FLAGS_W)) u_div_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_valid),
        .i_rem   (30'(r_b[31:17])),
        .i_den   (r5_lnq),
        .i_num   ({r_b[16:0], 24'h0}),
        .i_side  (d2_in_flags),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    assign d2_flags = t_flags'(d2_side);

    // celsius offset and scale products
    logic        sub_en;
    logic        cold;
    logic [40:0] t_adj;
    t_flags      n_r6_flags;
    logic        r6_valid;
    logic [43:0] r6_pl;
    logic [43:0] r6_ph;
    t_flags      r6_flags;

    assign sub_en = r_cels && !d2_flags.inf && !d2_flags.big;
    assign cold   = sub_en && (d2_quo <= KZERO_Q16);
    assign t_adj  = sub_en ? (d2_quo - KZERO_Q16) : d2_quo;

    always_comb begin
        n_r6_flags      = d2_flags;
        n_r6_flags.zero = d2_flags.zero || cold || (r_scale == '0);
        n_r6_flags.big  = d2_flags.big || (!cold && t_adj[40]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (en) begin
            r6_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_pl    <= 44'(t_adj[19:0]) * 44'(r_scale);
            r6_ph    <= 44'(t_adj[39:20]) * 44'(r_scale);
            r6_flags <= n_r6_flags;
        end
    end

    // sum, clamp and output register
    logic [63:0] psum;
    logic [39:0] pq;
    logic [15:0] clamp;
    logic [15:0] n_val;

    assign psum  = {r6_ph, 20'h0} + 64'(r6_pl);
    assign pq    = psum[63:24];
    assign clamp = (pq[39:16] != '0) ? VAL_MAX : pq[15:0];

    always_comb begin
        if (r6_flags.err || r6_flags.zero) begin
            n_val = '0;
        end else if (r6_flags.inf || r6_flags.big) begin
            n_val = VAL_MAX;
        end else begin
            n_val = clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_val <= n_val;
            r_out_err <= r6_flags.err;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_scaled_temperature = r_out_val;
    assign o_domain_error       = r_out_err;

    // checks
    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_domain_error |-> o_scaled_temperature == '0)
        else $error("domain error with nonzero value");

    a_stall_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    a_rst_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

endmodule
